>>> design/ipvc_pkg.sv
// Shared types and constants for the interval paint visible color counter.
package ipvc_pkg;

  // Fixed field widths of the item and result ports.
  localparam int OpW  = 2;
  localparam int PosW = 10;
  localparam int CntW = 11;

  // Item opcodes.
  typedef enum logic [OpW-1:0] {
    OP_PAINT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_COUNT = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PAINT,
    ST_CLEAR,
    ST_LOAD,
    ST_CMP,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic paint;
    logic clear;
    logic load;
    logic shift;
    logic drain;
  } cell_cmd_t;

endpackage

>>> design/ipvc_cmod.sv
// Reduces a paint color modulo the number of colors by reciprocal multiply.
module ipvc_cmod #(
  parameter int COLORS = 1024
) (
  input  logic                                            clk_i,
  input  logic [ipvc_pkg::PosW-1:0]                       x_i,
  output logic [((COLORS > 1) ? $clog2(COLORS) : 1)-1:0] r_o
);
  import ipvc_pkg::*;

  localparam int CW = (COLORS > 1) ? $clog2(COLORS) : 1;
  // floor(2^20 / COLORS) never overshoots, so the quotient is low by at most one.
  localparam int RecipV = (1 << 20) / COLORS;
  localparam logic [29:0] Recip = 30'(RecipV);
  localparam logic [16:0] ColorsC = 17'(COLORS);

  logic [29:0]     prod_q;
  logic [PosW-1:0] quot;
  logic [PosW-1:0] qc_q;
  logic [PosW-1:0] rem_raw;
  logic [16:0]     rem_ext;
  logic [16:0]     rem_fix;

  // First stage: scaled quotient estimate.
  always_ff @(posedge clk_i) begin
    prod_q <= 30'(x_i) * Recip;
  end

  assign quot = prod_q[29:20];

  // Second stage: quotient times modulus, which never exceeds the input.
  always_ff @(posedge clk_i) begin
    qc_q <= PosW'({17'd0, quot} * {10'd0, ColorsC});
  end

  // Remainder estimate is below twice the modulus; one correction is enough.
  always_comb begin
    rem_raw = x_i - qc_q;
    rem_ext = {7'd0, rem_raw};
    if (rem_ext >= ColorsC) begin
      rem_fix = rem_ext - ColorsC;
    end else begin
      rem_fix = rem_ext;
    end
  end

  assign r_o = CW'(rem_fix);

endmodule

>>> design/ipvc_cell.sv
// One cell of the paint row: its color, a traveling copy and a unique flag.
module ipvc_cell #(
  parameter int IDX = 0,
  parameter int CW  = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ipvc_pkg::cell_cmd_t       cmd_i,
  input  logic [ipvc_pkg::PosW-1:0] lo_i,
  input  logic [ipvc_pkg::PosW-1:0] hi_i,
  input  logic [CW-1:0]             color_i,
  input  logic                      copy_valid_i,
  input  logic [CW-1:0]             copy_color_i,
  output logic                      copy_valid_o,
  output logic [CW-1:0]             copy_color_o,
  input  logic                      flag_i,
  output logic                      flag_o
);
  import ipvc_pkg::*;

  localparam logic [31:0] IdxU = 32'(IDX);

  logic          valid_q;
  logic [CW-1:0] color_q;
  logic          copy_valid_q;
  logic [CW-1:0] copy_color_q;
  logic          flag_q;
  logic          hit;

  // This cell lies inside the clipped paint range.
  assign hit = (32'(lo_i) <= IdxU) && (IdxU <= 32'(hi_i));

  // Stored color: painted cells become valid, a clear empties every cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
    end else if (cmd_i.paint && hit) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.paint && hit) begin
      color_q <= color_i;
    end
  end

  // Traveling copy: loaded from the cell, then shifted one cell right per cycle while shift is commanded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      copy_valid_q <= valid_q;
    end else if (cmd_i.shift) begin
      copy_valid_q <= copy_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      copy_color_q <= color_q;
    end else if (cmd_i.shift) begin
      copy_color_q <= copy_color_i;
    end
  end

  // Unique flag: cleared when a lower cell carries the same color, then drained left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.load) begin
      flag_q <= valid_q;
    end else if (cmd_i.shift) begin
      if (copy_valid_i && (copy_color_i == color_q)) begin
        flag_q <= 1'b0;
      end
    end else if (cmd_i.drain) begin
      flag_q <= flag_i;
    end
  end

  assign copy_valid_o = copy_valid_q;
  assign copy_color_o = copy_color_q;
  assign flag_o       = flag_q;

endmodule

>>> design/interval_paint_visible_color_count.sv
// Top level of the interval paint visible color counter.
//
//   Channel   Handshake                     Payload
//   item in   start / busy                  opcode_i, left_pos_i, right_pos_i, paint_color_i
//   result    result_valid_o (one cycle)    visible_count_o
//   config    last_slot_we_i                last_slot_i
//
// A paint keeps busy high through ST_MUL1 and ST_MUL2, for the color reduction
// multiplies, and ST_PAINT, in which every cell compares its own index. A clear
// passes through ST_CLEAR alone and an unused opcode does not raise busy. A count
// loads in ST_LOAD, shifts in ST_CMP, drains in ST_DRAIN and strobes its result in
// ST_OUT; top being the last slot in use, the copy chain shifts top times and the
// flag chain drains top+1 times. Reset empties every cell and sets the last slot
// to 1023. The receiver cannot stall; each result is shown for exactly one cycle.
module interval_paint_visible_color_count #(
  parameter int SLOTS  = 1024,
  parameter int COLORS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ipvc_pkg::OpW-1:0]  opcode_i,
  input  logic [ipvc_pkg::PosW-1:0] left_pos_i,
  input  logic [ipvc_pkg::PosW-1:0] right_pos_i,
  input  logic [ipvc_pkg::PosW-1:0] paint_color_i,
  input  logic                      last_slot_we_i,
  input  logic [ipvc_pkg::PosW-1:0] last_slot_i,
  output logic                      result_valid_o,
  output logic [ipvc_pkg::CntW-1:0] visible_count_o
);
  import ipvc_pkg::*;

  localparam int CW = (COLORS > 1) ? $clog2(COLORS) : 1;

  state_e          state_q, state_d;
  logic [PosW-1:0] step_q, step_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] last_slot_q;
  logic [PosW-1:0] lo_q, hi_q, color_q;
  logic [PosW-1:0] top;
  logic [PosW-1:0] hi_clip;
  logic [CW-1:0]   color_mod;
  logic            accept;
  cell_cmd_t       cmd;

  logic            copy_valid[SLOTS];
  logic [CW-1:0]   copy_color[SLOTS];
  logic            flag[SLOTS];

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_slot_q <= PosW'(1023);
    end else if (last_slot_we_i) begin
      last_slot_q <= last_slot_i;
    end
  end

  // Last slot in use is limited by the number of cells.
  always_comb begin
    if (32'(last_slot_q) > 32'(SLOTS - 1)) begin
      top = PosW'(SLOTS - 1);
    end else begin
      top = last_slot_q;
    end
  end

  assign hi_clip = (hi_q > top) ? top : hi_q;

  // Item fields are held for the whole operation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q    <= left_pos_i;
      hi_q    <= right_pos_i;
      color_q <= paint_color_i;
    end
  end

  ipvc_cmod #(
    .COLORS (COLORS)
  ) u_cmod (
    .clk_i (clk_i),
    .x_i   (color_q),
    .r_o   (color_mod)
  );

  // Sequencer state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and the command broadcast to the cells.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_e'(opcode_i))
            OP_PAINT: state_d = ST_MUL1;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_COUNT: state_d = ST_LOAD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_PAINT;
      ST_PAINT: begin
        cmd.paint = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        cnt_d    = '0;
        if (top == '0) begin
          state_d = ST_DRAIN;
          step_d  = '0;
        end else begin
          state_d = ST_CMP;
          step_d  = PosW'(1);
        end
      end
      ST_CMP: begin
        cmd.shift = 1'b1;
        if (step_q == top) begin
          state_d = ST_DRAIN;
          step_d  = '0;
        end else begin
          step_d = step_q + PosW'(1);
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        cnt_d     = cnt_q + CntW'(flag[0]);
        if (step_q == top) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + PosW'(1);
        end
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign result_valid_o  = (state_q == ST_OUT);
  assign visible_count_o = cnt_q;

  // Row of cells: copies travel right, unique flags drain left toward cell 0.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic          cv_in;
    logic [CW-1:0] cc_in;
    logic          fl_in;

    if (i == 0) begin : g_first
      assign cv_in = 1'b0;
      assign cc_in = '0;
    end else begin : g_mid
      assign cv_in = copy_valid[i-1];
      assign cc_in = copy_color[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign fl_in = 1'b0;
    end else begin : g_inner
      assign fl_in = flag[i+1];
    end

    ipvc_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .lo_i         (lo_q),
      .hi_i         (hi_clip),
      .color_i      (color_mod),
      .copy_valid_i (cv_in),
      .copy_color_i (cc_in),
      .copy_valid_o (copy_valid[i]),
      .copy_color_o (copy_color[i]),
      .flag_i       (fl_in),
      .flag_o       (flag[i])
    );
  end

endmodule

>>> design/ipvc_checker.sv
// Port-level checks for the interval paint visible color counter, with its bind.
module ipvc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [ipvc_pkg::OpW-1:0]  opcode_i,
  input logic                      result_valid_o,
  input logic [ipvc_pkg::CntW-1:0] visible_count_o
);
  import ipvc_pkg::*;

  // A result is only shown while the count is still in progress.
  a_result_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // Each result is strobed for a single cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // A taken count item keeps the block busy in the next cycle.
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_COUNT)) |=> busy)
    else $error("count item did not start");

  // No result appears in the cycle right after an item is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result too early");

  // The count never exceeds 1024, the default number of cells.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (visible_count_o <= CntW'(1024)))
    else $error("count out of range");

endmodule

bind interval_paint_visible_color_count ipvc_checker u_ipvc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .opcode_i        (opcode_i),
  .result_valid_o  (result_valid_o),
  .visible_count_o (visible_count_o)
);
